/* hdl/pbzx_pkg.sv */
// Shared types, codes and signature tables for the pbzx container deframer.
`timescale 1ns / 1ps

package pbzx_pkg;

    typedef enum logic [2:0] {
        PH_SIG      = 3'd0,
        PH_BSIZE    = 3'd1,
        PH_HDR      = 3'd2,
        PH_DATA     = 3'd3,
        PH_DONE     = 3'd4,
        PH_ERR_SIG  = 3'd5,
        PH_ERR_TRNC = 3'd6,
        PH_ERR_BIG  = 3'd7
    } t_phase;

    localparam logic [2:0] ST_PAYLOAD = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_BADSIG  = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_TOOBIG  = 3'd4;

    localparam int unsigned SizeBytes = 8;
    localparam int unsigned HdrBytes  = 16;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       block_last;
    } t_result;

    // Expected byte at signature positions 0 to 2: "pbz".
    function automatic logic [7:0] sig_prefix(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h70;
            2'd1:    b = 8'h62;
            default: b = 8'h7A;
        endcase
        return b;
    endfunction

    // Fourth signature byte: one of z, x, 4, e.
    function automatic logic fourth_ok(input logic [7:0] b);
        return (b == 8'h7A) || (b == 8'h78) || (b == 8'h34) || (b == 8'h65);
    endfunction

endpackage

/* hdl/pbzx_container_deframer.sv */
// Top level of the pbzx container deframer: input register, parser, result buffer.
`timescale 1ns / 1ps

// Takes one container byte (or, with tuser set, an end-of-stream marker) per
// transfer and sustains one transfer per cycle while the result buffer has
// room. Each byte is held in an input register, decoded by the parser and,
// where it causes a result, written to a two-entry result buffer that holds
// it for the output. Header bytes give no result unless a check fails.
// After a clean end or an error every further transfer repeats that status
// until reset. s_axis_tready depends only on registered state.
module pbzx_container_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] end_marker
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0] m_axis_tuser,   // [2:0] status
    output logic       m_axis_tlast    // block_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic              step;
    logic              has_result;
    logic              buf_full;
    pbzx_pkg::t_result result;
    pbzx_pkg::t_result out_result;

    // Advance the held byte whenever the buffer has room.
    assign step          = r_in_valid && !buf_full;
    assign s_axis_tready = !r_in_valid || !buf_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tuser;
        end
    end

    pbzx_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_end        (r_in_end),
        .o_has_result (has_result),
        .o_result     (result)
    );

    pbzx_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step && has_result),
        .i_result    (result),
        .o_full      (buf_full),
        .o_valid     (m_axis_tvalid),
        .o_result    (out_result),
        .i_pop_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_result.payload_byte;
    assign m_axis_tuser = out_result.status;
    assign m_axis_tlast = out_result.block_last;

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && buf_full) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held byte lost while buffer full");

endmodule

/* hdl/pbzx_parse.sv */
// Container parser: phase state, field assembly and per-byte result decode.
`timescale 1ns / 1ps

module pbzx_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    output logic                  o_has_result,
    output pbzx_pkg::t_result     o_result
);

    pbzx_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_pos, n_pos;
    logic             r_sig_bad, n_sig_bad;
    logic [63:0]      r_field, n_field;
    logic [63:0]      r_limit, n_limit;
    logic [63:0]      r_uncomp, n_uncomp;
    logic [63:0]      r_left, n_left;

    logic [63:0] field_sh;
    logic        sig_bad_now;

    assign field_sh = {r_field[55:0], i_byte};

    // Next-state logic
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sig_bad = r_sig_bad;
        n_field   = r_field;
        n_limit   = r_limit;
        n_uncomp  = r_uncomp;
        n_left    = r_left;
        sig_bad_now = r_sig_bad;
        if (r_phase == pbzx_pkg::PH_SIG || r_phase == pbzx_pkg::PH_BSIZE ||
            r_phase == pbzx_pkg::PH_HDR || r_phase == pbzx_pkg::PH_DATA) begin
            if (i_end) begin
                if (r_phase == pbzx_pkg::PH_HDR && r_pos == 4'd0) begin
                    n_phase = pbzx_pkg::PH_DONE;
                end else begin
                    n_phase = pbzx_pkg::PH_ERR_TRNC;
                end
            end else begin
                case (r_phase)
                    pbzx_pkg::PH_SIG: begin
                        if (r_pos < 4'd3) begin
                            if (i_byte != pbzx_pkg::sig_prefix(r_pos[1:0])) begin
                                n_sig_bad = 1'b1;
                            end
                            n_pos = r_pos + 4'd1;
                        end else begin
                            sig_bad_now = r_sig_bad || !pbzx_pkg::fourth_ok(i_byte);
                            n_sig_bad   = sig_bad_now;
                            n_pos       = 4'd0;
                            n_field     = '0;
                            n_phase     = sig_bad_now ? pbzx_pkg::PH_ERR_SIG
                                                      : pbzx_pkg::PH_BSIZE;
                        end
                    end
                    pbzx_pkg::PH_BSIZE: begin
                        if (r_pos < 4'(pbzx_pkg::SizeBytes - 1)) begin
                            n_field = field_sh;
                            n_pos   = r_pos + 4'd1;
                        end else begin
                            n_limit = field_sh;
                            n_field = '0;
                            n_pos   = 4'd0;
                            n_phase = pbzx_pkg::PH_HDR;
                        end
                    end
                    pbzx_pkg::PH_HDR: begin
                        n_field = field_sh;
                        if (r_pos == 4'(pbzx_pkg::SizeBytes - 1)) begin
                            n_uncomp = field_sh;
                            n_field  = '0;
                        end
                        if (r_pos < 4'(pbzx_pkg::HdrBytes - 1)) begin
                            n_pos = r_pos + 4'd1;
                        end else begin
                            n_pos   = 4'd0;
                            n_field = '0;
                            if (r_limit != '0 && r_uncomp > r_limit) begin
                                n_phase = pbzx_pkg::PH_ERR_BIG;
                            end else begin
                                n_left  = field_sh;
                                n_phase = (field_sh != '0) ? pbzx_pkg::PH_DATA
                                                           : pbzx_pkg::PH_HDR;
                            end
                        end
                    end
                    default: begin
                        n_left = r_left - 64'd1;
                        if (r_left == 64'd1) begin
                            n_phase = pbzx_pkg::PH_HDR;
                        end
                    end
                endcase
            end
        end
    end

    // Result decode
    always_comb begin
        o_has_result = 1'b0;
        o_result     = '0;
        case (r_phase)
            pbzx_pkg::PH_DONE: begin
                o_has_result    = 1'b1;
                o_result.status = pbzx_pkg::ST_END;
            end
            pbzx_pkg::PH_ERR_SIG: begin
                o_has_result    = 1'b1;
                o_result.status = pbzx_pkg::ST_BADSIG;
            end
            pbzx_pkg::PH_ERR_TRNC: begin
                o_has_result    = 1'b1;
                o_result.status = pbzx_pkg::ST_TRUNC;
            end
            pbzx_pkg::PH_ERR_BIG: begin
                o_has_result    = 1'b1;
                o_result.status = pbzx_pkg::ST_TOOBIG;
            end
            pbzx_pkg::PH_DATA: begin
                o_has_result = 1'b1;
                if (i_end) begin
                    o_result.status = pbzx_pkg::ST_TRUNC;
                end else begin
                    o_result.status       = pbzx_pkg::ST_PAYLOAD;
                    o_result.payload_byte = i_byte;
                    o_result.block_last   = (r_left == 64'd1);
                end
            end
            default: begin
                // Header phases report only on a failed check or an end marker.
                case (n_phase)
                    pbzx_pkg::PH_DONE: begin
                        o_has_result    = 1'b1;
                        o_result.status = pbzx_pkg::ST_END;
                    end
                    pbzx_pkg::PH_ERR_SIG: begin
                        o_has_result    = 1'b1;
                        o_result.status = pbzx_pkg::ST_BADSIG;
                    end
                    pbzx_pkg::PH_ERR_TRNC: begin
                        o_has_result    = 1'b1;
                        o_result.status = pbzx_pkg::ST_TRUNC;
                    end
                    pbzx_pkg::PH_ERR_BIG: begin
                        o_has_result    = 1'b1;
                        o_result.status = pbzx_pkg::ST_TOOBIG;
                    end
                    default: begin
                        o_has_result = 1'b0;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pbzx_pkg::PH_SIG;
            r_pos     <= '0;
            r_sig_bad <= 1'b0;
            r_field   <= '0;
            r_limit   <= '0;
            r_uncomp  <= '0;
            r_left    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_sig_bad <= n_sig_bad;
            r_field   <= n_field;
            r_limit   <= n_limit;
            r_uncomp  <= n_uncomp;
            r_left    <= n_left;
        end
    end

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbzx_pkg::PH_DATA) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    a_sticky_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbzx_pkg::PH_DONE || r_phase == pbzx_pkg::PH_ERR_SIG ||
         r_phase == pbzx_pkg::PH_ERR_TRNC || r_phase == pbzx_pkg::PH_ERR_BIG)
        |=> (r_phase == $past(r_phase)))
        else $error("terminal phase left without reset");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has_result && o_result.status != pbzx_pkg::ST_PAYLOAD)
        |-> (!o_result.block_last && o_result.payload_byte == 8'd0))
        else $error("status result carries payload fields");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pbzx_pkg::PH_SIG) |-> (r_pos < 4'd4))
        else $error("signature position out of range");

endmodule

/* hdl/pbzx_skid.sv */
// Two-entry result buffer between the parser and the output stream.
`timescale 1ns / 1ps

module pbzx_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pbzx_pkg::t_result  i_result,
    output logic               o_full,
    output logic               o_valid,
    output pbzx_pkg::t_result  o_result,
    input  logic               i_pop_ready
);

    pbzx_pkg::t_result r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full result buffer");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("buffer pointers disagree with count");

endmodule

/* dv/pbzx_container_deframer_tb.sv */
// Self-checking testbench for the pbzx container deframer: byte stream in, payload out.
`timescale 1ns / 1ps

module pbzx_container_deframer_tb;

    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam logic [63:0] ALL_ONES     = '1;
    localparam logic [23:0] SIG_PREFIX   = 24'h70627A;    // p b z
    localparam logic [31:0] SIG_FOURTH   = 32'h7A783465;  // z x 4 e

    typedef struct {
        logic              eom;
        logic [7:0]        data;
        bit                typed;
        pbzx_pkg::t_result res;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] in_byte
    logic       s_axis_tuser = 1'b0;     // [0] end_marker
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] payload_byte
    logic [2:0] m_axis_tuser;            // [2:0] status
    logic       m_axis_tlast;            // block_last

    // Deframer state as the stream walks it
    pbzx_pkg::t_phase p_phase = pbzx_pkg::PH_SIG;
    logic [3:0]  p_pos = '0;
    logic        p_sig_bad = 1'b0;
    logic [63:0] p_shift = '0;
    logic [63:0] p_limit = '0;
    logic [63:0] p_uncomp = '0;
    logic [63:0] p_left = '0;

    pbzx_pkg::t_result results_due[$];
    t_row        dir_rows[$];
    logic [63:0] stream_limit;
    bit          calm = 1'b0;
    int          errors = 0;
    int          n_items = 0;
    int          n_payload = 0;
    int          n_blocks = 0;
    int          n_empty = 0;
    int          n_checked = 0;
    string       end_kind = "none";

    pbzx_container_deframer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the deframer by one item; returns 1 when the item yields a result.
    function automatic bit deframe_step(input logic eom, input logic [7:0] b,
                                        output pbzx_pkg::t_result r);
        r = '0;
        case (p_phase)
            pbzx_pkg::PH_DONE: begin
                r.status = pbzx_pkg::ST_END;
                return 1'b1;
            end
            pbzx_pkg::PH_ERR_SIG: begin
                r.status = pbzx_pkg::ST_BADSIG;
                return 1'b1;
            end
            pbzx_pkg::PH_ERR_TRNC: begin
                r.status = pbzx_pkg::ST_TRUNC;
                return 1'b1;
            end
            pbzx_pkg::PH_ERR_BIG: begin
                r.status = pbzx_pkg::ST_TOOBIG;
                return 1'b1;
            end
            default: ;
        endcase
        if (eom) begin
            // only a header boundary is a clean place to stop
            if (p_phase == pbzx_pkg::PH_HDR && p_pos == 4'd0) begin
                p_phase  = pbzx_pkg::PH_DONE;
                r.status = pbzx_pkg::ST_END;
            end else begin
                p_phase  = pbzx_pkg::PH_ERR_TRNC;
                r.status = pbzx_pkg::ST_TRUNC;
            end
            return 1'b1;
        end
        case (p_phase)
            pbzx_pkg::PH_SIG: begin
                if (p_pos < 4'd3) begin
                    if (b != SIG_PREFIX[23 - 8 * p_pos[1:0] -: 8])
                        p_sig_bad = 1'b1;
                    p_pos = p_pos + 4'd1;
                    return 1'b0;
                end
                if (!(b == 8'h7A || b == 8'h78 || b == 8'h34 || b == 8'h65))
                    p_sig_bad = 1'b1;
                p_pos = '0;
                if (p_sig_bad) begin
                    p_phase  = pbzx_pkg::PH_ERR_SIG;
                    r.status = pbzx_pkg::ST_BADSIG;
                    return 1'b1;
                end
                p_shift = '0;
                p_phase = pbzx_pkg::PH_BSIZE;
                return 1'b0;
            end
            pbzx_pkg::PH_BSIZE: begin
                p_shift = {p_shift[55:0], b};
                if (p_pos < 4'd7) begin
                    p_pos = p_pos + 4'd1;
                    return 1'b0;
                end
                p_limit = p_shift;
                p_shift = '0;
                p_pos   = '0;
                p_phase = pbzx_pkg::PH_HDR;
                return 1'b0;
            end
            pbzx_pkg::PH_HDR: begin
                p_shift = {p_shift[55:0], b};
                if (p_pos == 4'd7) begin
                    p_uncomp = p_shift;
                    p_shift  = '0;
                end
                if (p_pos < 4'd15) begin
                    p_pos = p_pos + 4'd1;
                    return 1'b0;
                end
                p_pos = '0;
                if (p_limit != 0 && p_uncomp > p_limit) begin
                    p_shift  = '0;
                    p_phase  = pbzx_pkg::PH_ERR_BIG;
                    r.status = pbzx_pkg::ST_TOOBIG;
                    return 1'b1;
                end
                p_left  = p_shift;
                p_shift = '0;
                // an empty block goes straight on to the next header
                p_phase = (p_left != 0) ? pbzx_pkg::PH_DATA : pbzx_pkg::PH_HDR;
                return 1'b0;
            end
            default: begin
                r.status       = pbzx_pkg::ST_PAYLOAD;
                r.payload_byte = b;
                r.block_last   = (p_left == 64'd1);
                p_left         = p_left - 64'd1;
                if (p_left == 0)
                    p_phase = pbzx_pkg::PH_HDR;
                return 1'b1;
            end
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then log what it should yield.
    task automatic send_item(input logic eom, input logic [7:0] b,
                             input bit typed, input pbzx_pkg::t_result want);
        pbzx_pkg::t_result r;
        bit      has;
        while (!calm && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= eom;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        has = deframe_step(eom, b, r);
        if (typed)
            results_due.push_back(want);
        else if (has)
            results_due.push_back(r);
        if (has && r.status == pbzx_pkg::ST_PAYLOAD)
            n_payload++;
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic send_field(input logic [63:0] v);
        for (int i = 7; i >= 0; i--)
            send_item(1'b0, v[i * 8 +: 8], 1'b0, '0);
    endtask

    task automatic send_payload(input int unsigned cnt);
        for (int unsigned i = 0; i < cnt; i++)
            send_item(1'b0, 8'($urandom), 1'b0, '0);
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic drain_results();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    // Uncompressed size that stays within the stream's limit.
    function automatic logic [63:0] pick_uncomp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (stream_limit == 0 || stream_limit == ALL_ONES)
            return ($urandom_range(7) == 0) ? ALL_ONES : v;
        if ($urandom_range(7) == 0)
            return stream_limit;
        return v % (stream_limit + 64'd1);
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin
        pbzx_pkg::t_result got;
        pbzx_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
            n_checked++;
            if (results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status %0d byte %h last %b",
                         $time, got.status, got.payload_byte, got.block_last);
            end else begin
                want = results_due.pop_front();
                if (got.status != want.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, got.status);
                end
                if (got.payload_byte != want.payload_byte) begin
                    errors++;
                    $display("%0t: payload byte expected %h got %h",
                             $time, want.payload_byte, got.payload_byte);
                end
                if (got.block_last != want.block_last) begin
                    errors++;
                    $display("%0t: block last expected %b got %b",
                             $time, want.block_last, got.block_last);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("pbzx_container_deframer_tb failed");
        $finish;
    end

    initial begin
        logic [7:0]  fourth;
        logic [63:0] dir_uncomp;
        logic [63:0] uncomp;
        int unsigned comp;
        bit          paused;
        pbzx_pkg::t_result left_over;

        paused = 1'b0;
        fourth = SIG_FOURTH[8 * $urandom_range(3) +: 8];
        case ($urandom_range(2))
            0:       stream_limit = '0;
            1:       stream_limit = 64'($urandom_range(1, 100000));
            default: stream_limit = ALL_ONES;
        endcase
        // header size equal to the limit must still pass
        dir_uncomp = (stream_limit == 0 || stream_limit == ALL_ONES) ? ALL_ONES
                                                                     : stream_limit;

        // eom, byte, typed, expected result
        dir_rows = '{
            '{1'b0, 8'h70,              1'b0, '0},
            '{1'b0, 8'h62,              1'b0, '0},
            '{1'b0, 8'h7A,              1'b0, '0},
            '{1'b0, fourth,             1'b0, '0},
            '{1'b0, stream_limit[63:56], 1'b0, '0},
            '{1'b0, stream_limit[55:48], 1'b0, '0},
            '{1'b0, stream_limit[47:40], 1'b0, '0},
            '{1'b0, stream_limit[39:32], 1'b0, '0},
            '{1'b0, stream_limit[31:24], 1'b0, '0},
            '{1'b0, stream_limit[23:16], 1'b0, '0},
            '{1'b0, stream_limit[15:8],  1'b0, '0},
            '{1'b0, stream_limit[7:0],   1'b0, '0},
            '{1'b0, dir_uncomp[63:56],  1'b0, '0},
            '{1'b0, dir_uncomp[55:48],  1'b0, '0},
            '{1'b0, dir_uncomp[47:40],  1'b0, '0},
            '{1'b0, dir_uncomp[39:32],  1'b0, '0},
            '{1'b0, dir_uncomp[31:24],  1'b0, '0},
            '{1'b0, dir_uncomp[23:16],  1'b0, '0},
            '{1'b0, dir_uncomp[15:8],   1'b0, '0},
            '{1'b0, dir_uncomp[7:0],    1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h00,              1'b0, '0},
            '{1'b0, 8'h02,              1'b0, '0},
            '{1'b0, 8'hFF, 1'b1, pbzx_pkg::t_result'{pbzx_pkg::ST_PAYLOAD, 8'hFF, 1'b0}},
            '{1'b0, 8'h00, 1'b1, pbzx_pkg::t_result'{pbzx_pkg::ST_PAYLOAD, 8'h00, 1'b1}}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].eom, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);
        n_blocks++;

        // well-formed blocks with random content; a quiet stretch in the middle
        while (n_items < dir_rows.size() + RANDOM_ITEMS) begin
            calm = (n_items >= 900 && n_items < 1200);
            if (!paused && n_items >= 600) begin
                drain_results();
                paused = 1'b1;
            end
            case ($urandom_range(15))
                0, 1:    comp = 0;
                2:       comp = $urandom_range(150, 300);
                default: comp = $urandom_range(1, 24);
            endcase
            send_field(pick_uncomp());
            send_field(64'(comp));
            send_payload(comp);
            n_blocks++;
            if (comp == 0)
                n_empty++;
        end
        calm = 1'b0;

        // let everything settle, then close the stream one way or another
        drain_results();
        case ($urandom_range(3))
            0: begin
                end_kind = "clean end";
                send_item(1'b1, 8'($urandom), 1'b0, '0);
            end
            1: begin
                end_kind = "truncated payload";
                comp = $urandom_range(2, 20);
                send_field(pick_uncomp());
                send_field(64'(comp));
                send_payload($urandom_range(1, comp - 1));
                send_item(1'b1, 8'($urandom), 1'b0, '0);
            end
            2: begin
                if (stream_limit != 0 && stream_limit != ALL_ONES) begin
                    end_kind = "block too large";
                    uncomp = $urandom_range(1) ? ALL_ONES
                                               : stream_limit + 64'($urandom_range(1, 1000));
                    send_field(uncomp);
                    send_field(64'($urandom_range(24)));
                end else begin
                    end_kind = "truncated header";
                    send_payload($urandom_range(1, 15));
                    send_item(1'b1, 8'($urandom), 1'b0, '0);
                end
            end
            default: begin
                end_kind = "truncated header";
                send_payload($urandom_range(1, 15));
                send_item(1'b1, 8'($urandom), 1'b0, '0);
            end
        endcase
        // status must stick whatever follows
        repeat (16)
            send_item(1'($urandom_range(1)), 8'($urandom), 1'b0, '0);

        drain_results();
        repeat (8) @(posedge i_clk);
        while (results_due.size() != 0) begin
            left_over = results_due.pop_front();
            errors++;
            $display("%0t: missing result status %0d byte %h last %b", $time,
                     left_over.status, left_over.payload_byte, left_over.block_last);
        end

        $display("covered %0d items: %0d blocks (%0d empty), %0d payload bytes, %0d results",
                 n_items, n_blocks, n_empty, n_payload, n_checked);
        $display("block size limit %h, stream closed by %s, then sticky status",
                 stream_limit, end_kind);
        if (errors == 0) begin
            $display("pbzx_container_deframer_tb passed");
        end else begin
            $display("pbzx_container_deframer_tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/pbzx_pkg.sv
hdl/pbzx_parse.sv
hdl/pbzx_skid.sv
hdl/pbzx_container_deframer.sv
dv/pbzx_container_deframer_tb.sv
